[hw/rtl/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the point similarity transform.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int COEF_W    = 20;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int SCALE_W   = 32;
  localparam int COORD_W   = 64;
  localparam int NUM_AXES  = 3;
  localparam int LANE_STG  = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X  = 3'd0,
    REG_ROT_Y  = 3'd1,
    REG_ROT_Z  = 3'd2,
    REG_SCALE  = 3'd3,
    REG_SHIFTX = 3'd4,
    REG_SHIFTY = 3'd5,
    REG_SHIFTZ = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord;
    logic                      sat;
  } pst_res_t;

endpackage

[hw/rtl/point_similarity_transform_sat_top.sv]
// ----------------------------------------------------------------------------
// point_similarity_transform_sat_top
// Fixed-point 3D similarity transform with rounding and saturation.
// ----------------------------------------------------------------------------
// Each transaction on the slave side carries one point and yields one result on
// the master side. Three axis lanes, each a 7-stage pipeline
// (split multiplies for the dot product, split multiply by the scale,
// translate, round and clamp), feed one output register, so a new point is
// taken every cycle while the downstream side keeps up; a stall fills the
// stages back to front before tready drops. Write configuration only while
// no points are in flight.
// ----------------------------------------------------------------------------
module point_similarity_transform_sat_top import pst_pkg::*; #(
  parameter int COEF_FRAC_BITS  = 18,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [NUM_AXES*COORD_W-1:0] s_tdata,   // in_x, in_y, in_z
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [NUM_AXES*COORD_W-1:0] m_tdata,   // out_x, out_y, out_z
  output logic                        m_tuser,   // saturated
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [63:0]                 cfg_data
);

  localparam int FRAC = COEF_FRAC_BITS + SCALE_FRAC_BITS;

  logic [ROW_W-1:0]          rot   [NUM_AXES];
  logic signed [SCALE_W-1:0] scale;
  logic signed [COORD_W-1:0] shift [NUM_AXES];

  logic [LANE_STG-1:0]       vld;
  logic [LANE_STG-1:0]       en;
  logic                      out_load;
  pst_res_t [NUM_AXES-1:0]   lane_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= ROW_W'(1) << COEF_FRAC_BITS;
      rot[1] <= ROW_W'(1) << (COEF_W + COEF_FRAC_BITS);
      rot[2] <= ROW_W'(1) << (2 * COEF_W + COEF_FRAC_BITS);
      scale  <= SCALE_W'(1) << SCALE_FRAC_BITS;
      for (int a = 0; a < NUM_AXES; a++) begin
        shift[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_ROT_X:  rot[0]   <= cfg_data[ROW_W-1:0];
        REG_ROT_Y:  rot[1]   <= cfg_data[ROW_W-1:0];
        REG_ROT_Z:  rot[2]   <= cfg_data[ROW_W-1:0];
        REG_SCALE:  scale    <= cfg_data[SCALE_W-1:0];
        REG_SHIFTX: shift[0] <= cfg_data;
        REG_SHIFTY: shift[1] <= cfg_data;
        REG_SHIFTZ: shift[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[LANE_STG-1] = ~vld[LANE_STG-1] | out_load;
    for (int i = LANE_STG - 2; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < LANE_STG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    pst_lane #(
      .FRAC(FRAC)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .point(s_tdata),
      .row  (rot[a]),
      .scl  (scale),
      .tr   (shift[a]),
      .res  (lane_res[a])
    );
  end

  pst_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .in_valid(vld[LANE_STG-1]),
    .load    (out_load),
    .lane_res(lane_res),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted point did not enter the pipeline");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !(|vld) && !m_tvalid |-> s_tready)
    else $error("empty pipeline refuses input");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !out_load)
    else $error("output register reloaded during stall");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[63:0] == {1'b0, {63{1'b1}}}) || (m_tdata[63:0] == {1'b1, {63{1'b0}}}) ||
      (m_tdata[127:64] == {1'b0, {63{1'b1}}}) ||
      (m_tdata[127:64] == {1'b1, {63{1'b0}}}) ||
      (m_tdata[191:128] == {1'b0, {63{1'b1}}}) ||
      (m_tdata[191:128] == {1'b1, {63{1'b0}}}))
    else $error("saturation flag without a clamped coordinate");

endmodule

[hw/rtl/pst_lane.sv]
// ----------------------------------------------------------------------------
// pst_lane
// One axis: rotation row dot product, scale, translate, round, saturate.
// ----------------------------------------------------------------------------
module pst_lane import pst_pkg::*; #(
  parameter int FRAC = 34
) (
  input  logic                      clk,
  input  logic [LANE_STG-1:0]       en,
  input  logic [NUM_AXES*COORD_W-1:0] point,
  input  logic [ROW_W-1:0]          row,
  input  logic signed [SCALE_W-1:0] scl,
  input  logic signed [COORD_W-1:0] tr,
  output pst_res_t                  res
);

  localparam int VW   = 119;
  localparam int TW   = ((VW > COORD_W + FRAC) ? VW : COORD_W + FRAC) + 1;
  localparam int RW   = TW + 1;
  localparam logic [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (FRAC - 1);

  logic signed [52:0] plo [NUM_AXES];
  logic signed [51:0] phi [NUM_AXES];
  logic signed [54:0] lo_sum;
  logic signed [53:0] hi_sum;
  logic signed [85:0] acc;
  logic signed [64:0] q0;
  logic signed [64:0] q1;
  logic signed [53:0] q2;
  logic signed [VW-1:0] v;
  logic signed [TW-1:0] t;
  logic signed [RW-1:0] rnd;
  logic signed [RW-1:0] shr;
  logic                 fits;

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      if (en[0]) begin
        plo[k] <= $signed(row[COEF_W*k +: COEF_W]) *
                  $signed({1'b0, point[COORD_W*k +: 32]});
        phi[k] <= $signed(row[COEF_W*k +: COEF_W]) *
                  $signed(point[COORD_W*k + 32 +: 32]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lo_sum <= 55'(plo[0]) + 55'(plo[1]) + 55'(plo[2]);
      hi_sum <= 54'(phi[0]) + 54'(phi[1]) + 54'(phi[2]);
    end
    if (en[2]) begin
      acc <= (86'(hi_sum) <<< 32) + 86'(lo_sum);
    end
    if (en[3]) begin
      q0 <= $signed({1'b0, acc[31:0]}) * scl;
      q1 <= $signed({1'b0, acc[63:32]}) * scl;
      q2 <= $signed(acc[85:64]) * scl;
    end
    if (en[4]) begin
      v <= (VW'(q2) <<< 64) + (VW'(q1) <<< 32) + VW'(q0);
    end
    if (en[5]) begin
      t <= TW'(v) + (TW'(tr) <<< FRAC);
    end
  end

  always_comb begin
    rnd  = RW'(t) + (t[TW-1] ? $signed(HALF - RW'(1)) : $signed(HALF));
    shr  = rnd >>> FRAC;
    fits = (&shr[RW-1:COORD_W-1]) | ~(|shr[RW-1:COORD_W-1]);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      res.sat <= ~fits;
      if (fits) begin
        res.coord <= shr[COORD_W-1:0];
      end else if (shr[RW-1]) begin
        res.coord <= {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        res.coord <= {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

endmodule

[hw/rtl/pst_merge.sv]
// ----------------------------------------------------------------------------
// pst_merge
// Output register: joins the three lane results and the saturation flags.
// ----------------------------------------------------------------------------
module pst_merge import pst_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          load,
  input  pst_res_t [NUM_AXES-1:0]       lane_res,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [NUM_AXES*COORD_W-1:0]   m_tdata,
  output logic                          m_tuser
);

  assign load = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {lane_res[2].coord, lane_res[1].coord, lane_res[0].coord};
      m_tuser <= lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
    end
  end

endmodule

[tb/point_similarity_transform_sat_top_tb.sv]
// ----------------------------------------------------------------------------
// point_similarity_transform_sat_top_tb
// Self-checking bench for the fixed-point 3D similarity transform.
// ----------------------------------------------------------------------------
// A queue of points feeds a clocked driver on the slave side. Every accepted
// point is run through an exact 128-bit transform (dot product, scale,
// translate, round half away from zero, clamp) using a local copy of the
// registers, and the result is queued. A clocked monitor checks every master
// side transaction against the oldest queued result. Directed phases cover the
// reset registers, rounding ties, coefficient and scale extremes and both
// saturation limits; random phases then vary the registers and the handshake
// pressure on both sides. Registers are only written once the pipe is empty.
// ----------------------------------------------------------------------------
module point_similarity_transform_sat_top_tb;
  import pst_pkg::*;

  localparam int COEF_FRAC  = 18;
  localparam int SCALE_FRAC = 16;
  localparam int FRAC_BITS  = COEF_FRAC + SCALE_FRAC;
  localparam int IDLE_LIMIT = 5000;
  localparam int MAX_REPORTS = 100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [63:0] C_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] C_MIN = 64'h8000_0000_0000_0000;
  localparam logic [COEF_W-1:0] COEF_MAX = 20'h7FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 20'h80000;
  localparam logic [ROW_W-1:0] ROW_IDENT_X = 60'd1 << COEF_FRAC;
  localparam logic [ROW_W-1:0] ROW_IDENT_Y = 60'd1 << (COEF_FRAC + COEF_W);
  localparam logic [ROW_W-1:0] ROW_IDENT_Z = 60'd1 << (COEF_FRAC + 2 * COEF_W);

  typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord3_t;

  typedef struct packed {
    coord3_t coords;
    logic    sat;
  } xform_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  coord3_t                     s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [NUM_AXES*COORD_W-1:0] m_tdata;
  logic                        m_tuser;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [63:0]                 cfg_data = '0;

  logic [ROW_W-1:0]         rot_rows [NUM_AXES];
  logic signed [SCALE_W-1:0] scale_q;
  logic signed [COORD_W-1:0] shifts [NUM_AXES];

  coord3_t       pending_points [$];
  xform_result_t expected_results [$];
  xform_result_t want;
  coord3_t       got_coords;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            mismatches = 0;
  int            idle_cycles = 0;

  point_similarity_transform_sat_top #(
    .COEF_FRAC_BITS (COEF_FRAC),
    .SCALE_FRAC_BITS(SCALE_FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic xform_result_t transform_point(coord3_t p);
    xform_result_t         r;
    logic signed [127:0]   acc;
    logic signed [127:0]   cw;
    logic signed [127:0]   pw;
    logic signed [127:0]   sw;
    logic signed [127:0]   tw;
    logic signed [COEF_W-1:0] coef;
    logic [127:0]          mag;
    logic                  neg;
    r.sat = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        coef = rot_rows[a][COEF_W*k +: COEF_W];
        cw = coef;
        pw = $signed(p[k]);
        acc = acc + cw * pw;
      end
      sw = scale_q;
      tw = shifts[a];
      acc = acc * sw + (tw <<< FRAC_BITS);
      neg = acc[127];
      mag = neg ? -acc : acc;
      mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (!neg) begin
        if (mag > {64'd0, C_MAX}) begin
          r.sat = 1'b1;
          r.coords[a] = C_MAX;
        end else begin
          r.coords[a] = mag[63:0];
        end
      end else if (mag > {64'd0, C_MIN}) begin
        r.sat = 1'b1;
        r.coords[a] = C_MIN;
      end else begin
        r.coords[a] = ~mag[63:0] + 64'd1;
      end
    end
    return r;
  endfunction

  task automatic flag_error(string what, logic [63:0] exp_v, logic [63:0] act_v);
    mismatches++;
    // hold output to a readable size
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %h actual %h", $time, what, exp_v, act_v);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(transform_point(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_points.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        got_coords = m_tdata;
        if (expected_results.size() == 0) begin
          flag_error("unexpected result, out_x", '0, got_coords[0]);
        end else begin
          want = expected_results.pop_front();
          for (int a = 0; a < NUM_AXES; a++)
            if (got_coords[a] !== want.coords[a])
              flag_error($sformatf("out axis %0d", a), want.coords[a], got_coords[a]);
          if (m_tuser !== want.sat)
            flag_error("saturated", 64'(want.sat), 64'(m_tuser));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROT_X:  rot_rows[0] = val[ROW_W-1:0];
      REG_ROT_Y:  rot_rows[1] = val[ROW_W-1:0];
      REG_ROT_Z:  rot_rows[2] = val[ROW_W-1:0];
      REG_SCALE:  scale_q = val[SCALE_W-1:0];
      REG_SHIFTX: shifts[0] = val;
      REG_SHIFTY: shifts[1] = val;
      REG_SHIFTZ: shifts[2] = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic program_all(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                             logic [ROW_W-1:0] rz, logic [SCALE_W-1:0] sc,
                             logic [63:0] tx, logic [63:0] ty, logic [63:0] tz);
    write_reg(REG_ROT_X, {4'($urandom_range(0, 15)), rx});
    write_reg(REG_ROT_Y, {4'($urandom_range(0, 15)), ry});
    write_reg(REG_ROT_Z, {4'($urandom_range(0, 15)), rz});
    write_reg(REG_SCALE, {$urandom, sc});
    write_reg(REG_SHIFTX, tx);
    write_reg(REG_SHIFTY, ty);
    write_reg(REG_SHIFTZ, tz);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_points.size() != 0 || s_tvalid || expected_results.size() != 0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_coord();
    logic signed [63:0] v;
    v = rand64();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3, 4: return v;
      default: return v >>> $urandom_range(1, 63);
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] row;
    logic [63:0]      v;
    int               c;
    v = rand64();
    row = v[ROW_W-1:0];
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        case ($urandom_range(0, 5))
          0: row[COEF_W*k +: COEF_W] = COEF_MAX;
          1: row[COEF_W*k +: COEF_W] = COEF_MIN;
          2: row[COEF_W*k +: COEF_W] = '0;
          default: begin
            c = int'($urandom_range(0, 524288)) - 262144;
            row[COEF_W*k +: COEF_W] = c[COEF_W-1:0];
          end
        endcase
      end
    end
    return row;
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    int s;
    s = int'($urandom_range(0, 262144)) - 131072;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return s;
    endcase
  endfunction

  initial begin
    rot_rows[0] = ROW_IDENT_X;
    rot_rows[1] = ROW_IDENT_Y;
    rot_rows[2] = ROW_IDENT_Z;
    scale_q = 32'sd65536;
    for (int a = 0; a < NUM_AXES; a++) shifts[a] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // registers at reset values: identity
    pending_points.push_back({64'd0, 64'd0, 64'd0});
    pending_points.push_back({C_MAX, C_MAX, C_MAX});
    pending_points.push_back({C_MIN, C_MIN, C_MIN});
    pending_points.push_back({C_MIN, -64'sd1, 64'd1});
    pending_points.push_back({64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA,
                              64'h5555_5555_5555_5555});
    wait_drained();

    // smallest weights: exact halves round away from zero
    program_all(60'd1, 60'hFFFFF << COEF_W, 60'(COEF_MIN) << (2 * COEF_W), 32'd1,
                '0, '0, '0);
    pending_points.push_back({64'd1 << 33, 64'd1 << 33, 64'd1 << 33});
    pending_points.push_back({64'd1 << 32, -(64'd1 << 33) + 64'd1, (64'd1 << 33) - 64'd1});
    pending_points.push_back({-(64'd1 << 32), -(64'd3 << 33), 64'd3 << 33});
    wait_drained();

    // largest coefficients, most negative scale
    program_all({COEF_MAX, COEF_MAX, COEF_MAX}, {COEF_MAX, COEF_MAX, COEF_MAX},
                {COEF_MAX, COEF_MAX, COEF_MAX}, 32'h8000_0000, C_MAX, C_MIN, '0);
    pending_points.push_back({C_MAX, C_MAX, C_MAX});
    pending_points.push_back({C_MIN, C_MIN, C_MIN});
    pending_points.push_back({64'd0, 64'd0, 64'd0});
    pending_points.push_back({64'd0, 64'd0, 64'd1});
    wait_drained();

    // translation to both range limits; exactly -2^63 is in range
    program_all(ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z, 32'd65536,
                -(64'd1 << 62), C_MAX, C_MIN);
    pending_points.push_back({-64'sd1, 64'd1, -(64'd1 << 62)});
    pending_points.push_back({64'd0, 64'd0, -(64'd1 << 62) - 64'd1});
    pending_points.push_back({64'd0, 64'd0, 64'd0});
    pending_points.push_back({64'd1, -64'sd1, -(64'd1 << 62)});
    wait_drained();

    // most negative coefficients, largest scale; the unused index is dropped
    program_all({COEF_MIN, COEF_MIN, COEF_MIN}, {COEF_MIN, COEF_MIN, COEF_MIN},
                {COEF_MIN, COEF_MIN, COEF_MIN}, 32'h7FFF_FFFF, rand64(), rand64(),
                rand64());
    write_reg(REG_UNUSED, rand64());
    pending_points.push_back({64'd1, C_MIN, C_MAX});
    pending_points.push_back({-64'sd1, -64'sd1, -64'sd1});
    pending_points.push_back({64'd0, 64'd0, 64'd0});
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      program_all(rand_row(), rand_row(), rand_row(), rand_scale(),
                  rand_coord(), rand_coord(), rand_coord());
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      repeat (235) pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
